FILE: rtl/core/jtc_pkg.sv
// shared types, constants and codes for the joystick teleop controller
`default_nettype none

package jtc_pkg;

   // joystick axes
   localparam int NUM_AXES = 6;
   localparam int AXIS_W   = 10;

   // fixed axis slots
   localparam int AXIS_ZERO  = 0;
   localparam int AXIS_ONE   = 1;
   localparam int AXIS_TWO   = 2;
   localparam int AXIS_THREE = 3;
   localparam int AXIS_FOUR  = 4;
   localparam int AXIS_FIVE  = 5;

   // stick thresholds
   localparam logic [AXIS_W-1:0] JOG_HIGH = 10'd550;
   localparam logic [AXIS_W-1:0] JOG_LOW  = 10'd450;

   // joint limits in whole degrees, sub-degree steps per degree
   localparam logic [7:0] DEG_MAX    = 8'd180;
   localparam logic [6:0] STEP_TOP   = 7'd99;

   // direct servo scale: axis * 180 / 1024 == (axis * 45) >> 8
   localparam logic [5:0] SERVO_MUL = 6'd45;

   // track duty reciprocals, result is (d * k) >> 18, exact over the stick range
   localparam int          DUTY_SHIFT = 18;
   localparam logic [17:0] DUTY_K_FWD = 18'd141325; // 255 / 473
   localparam logic [17:0] DUTY_K_REV = 18'd148549; // 255 / 450

   // packet modes
   localparam logic MODE_ARM   = 1'b0;
   localparam logic MODE_DRIVE = 1'b1;

   typedef logic [AXIS_W-1:0] axis_type;
   typedef axis_type [NUM_AXES-1:0] axes_type;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   // joint position kept as whole degrees plus hundredths
   typedef struct packed {
      logic [7:0] deg;
      logic [6:0] frac;
   } joint_type;

   // per-pass control from the pipeline to the state units
   typedef struct packed {
      logic step;
      logic fresh;
      logic mode;
   } ctrl_type;

   typedef struct packed {
      logic [7:0] root_deg;
      logic [7:0] arm_a_deg;
      logic [7:0] arm_b_deg;
      logic [7:0] wrist_b_deg;
      logic [7:0] wrist_a;
      logic [7:0] gripper;
   } arm_out_type;

   typedef struct packed {
      logic [7:0] duty;
      dir_type    dir;
   } track_out_type;

endpackage

`default_nettype wire

FILE: rtl/core/joystick_teleop_controller.sv
// top level: input register, held packet and result handshake
// a transaction advances out of the input register into the state registers
// throughput: one transaction per cycle with rsp_tready high, the input register refills
// while a result waits; the joint, servo and track state registers are the result register
// reset (synchronous, active high) empties the pipeline, clears the held packet
// and puts the joints at 90, 40, 20 and 90 degrees, direct servos at 90, tracks stopped
`default_nettype none

module joystick_teleop_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // axis_zero .. axis_five, 10 bits each, zero fill
   input  wire logic [1:0]  req_tuser,  // fresh, mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata   // root_angle, arm_a_first_angle, arm_a_second_angle,
                                        // arm_b_angle, wrist_a_angle, wrist_b_angle,
                                        // gripper_angle, left_duty, left_dir, right_duty,
                                        // right_dir, zero fill
);

   logic                  in_valid_ff, in_valid_in;
   jtc_pkg::axes_type     in_axes_ff;
   logic                  in_fresh_ff;
   logic                  in_mode_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  held_mode_ff, held_mode_in;
   jtc_pkg::axes_type     held_axes_ff, held_axes_in;
   logic                  advance;
   logic                  req_take;
   jtc_pkg::ctrl_type     ctrl;
   jtc_pkg::axes_type     use_axes;
   jtc_pkg::arm_out_type  arm_angles;
   jtc_pkg::track_out_type left_track;
   jtc_pkg::track_out_type right_track;

   // pipeline handshake
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_axes_ff  <= jtc_pkg::axes_type'(req_tdata[jtc_pkg::NUM_AXES*jtc_pkg::AXIS_W-1:0]);
         in_fresh_ff <= req_tuser[0];
         in_mode_ff  <= req_tuser[1];
      end
   end

   // a fresh packet is used in its own pass and kept for later ones
   assign use_axes   = in_fresh_ff ? in_axes_ff : held_axes_ff;
   assign ctrl.step  = advance;
   assign ctrl.fresh = in_fresh_ff;
   assign ctrl.mode  = in_fresh_ff ? in_mode_ff : held_mode_ff;

   always_comb begin
      held_mode_in = held_mode_ff;
      held_axes_in = held_axes_ff;
      if (advance && in_fresh_ff) begin
         held_mode_in = in_mode_ff;
         held_axes_in = in_axes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_mode_ff <= jtc_pkg::MODE_ARM;
         held_axes_ff <= '0;
      end else begin
         held_mode_ff <= held_mode_in;
         held_axes_ff <= held_axes_in;
      end
   end

   jtc_arm u_arm (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .axes   (use_axes),
      .angles (arm_angles)
   );

   jtc_track u_left (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .axis  (use_axes[jtc_pkg::AXIS_ZERO]),
      .track (left_track)
   );

   jtc_track u_right (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .axis  (use_axes[jtc_pkg::AXIS_TWO]),
      .track (right_track)
   );

   // result packing, mirrored servos read 180 minus the joint angle
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0,
                        right_track.dir,
                        right_track.duty,
                        left_track.dir,
                        left_track.duty,
                        arm_angles.gripper,
                        arm_angles.wrist_b_deg,
                        arm_angles.wrist_a,
                        jtc_pkg::DEG_MAX - arm_angles.arm_b_deg,
                        jtc_pkg::DEG_MAX - arm_angles.arm_a_deg,
                        arm_angles.arm_a_deg,
                        arm_angles.root_deg};

endmodule

`default_nettype wire

FILE: rtl/core/jtc_arm.sv
// arm joint jog state and directly driven servos
`default_nettype none

module jtc_arm (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire jtc_pkg::ctrl_type ctrl,
   input  wire jtc_pkg::axes_type axes,
   output jtc_pkg::arm_out_type   angles
);

   jtc_pkg::joint_type root_ff, root_in;
   jtc_pkg::joint_type arm_a_ff, arm_a_in;
   jtc_pkg::joint_type arm_b_ff, arm_b_in;
   jtc_pkg::joint_type wrist_b_ff, wrist_b_in;
   logic [7:0]         wrist_a_ff, wrist_a_in;
   logic [7:0]         gripper_ff, gripper_in;
   logic               update;

   // one step up or down with saturation at 0 and 180 degrees
   function automatic jtc_pkg::joint_type jog(jtc_pkg::joint_type pos,
                                              jtc_pkg::axis_type axis);
      jtc_pkg::joint_type nxt;
      nxt = pos;
      if (axis >= jtc_pkg::JOG_HIGH) begin
         if (pos.deg != jtc_pkg::DEG_MAX) begin
            if (pos.frac == jtc_pkg::STEP_TOP) begin
               nxt.deg  = pos.deg + 8'd1;
               nxt.frac = 7'd0;
            end else begin
               nxt.frac = pos.frac + 7'd1;
            end
         end
      end else if (axis <= jtc_pkg::JOG_LOW) begin
         if (pos.frac != 7'd0) begin
            nxt.frac = pos.frac - 7'd1;
         end else if (pos.deg != 8'd0) begin
            nxt.deg  = pos.deg - 8'd1;
            nxt.frac = jtc_pkg::STEP_TOP;
         end
      end
      return nxt;
   endfunction

   // axis * 180 / 1024, truncated
   function automatic logic [7:0] scale_servo(jtc_pkg::axis_type axis);
      logic [15:0] prod;
      prod = 16'(axis) * 16'(jtc_pkg::SERVO_MUL);
      return prod[15:8];
   endfunction

   assign update = ctrl.step && (ctrl.mode == jtc_pkg::MODE_ARM);

   // next joint state
   always_comb begin
      root_in    = root_ff;
      arm_a_in   = arm_a_ff;
      arm_b_in   = arm_b_ff;
      wrist_b_in = wrist_b_ff;
      wrist_a_in = wrist_a_ff;
      gripper_in = gripper_ff;
      if (update) begin
         root_in    = jog(root_ff, axes[jtc_pkg::AXIS_ONE]);
         arm_a_in   = jog(arm_a_ff, axes[jtc_pkg::AXIS_ZERO]);
         arm_b_in   = jog(arm_b_ff, axes[jtc_pkg::AXIS_TWO]);
         wrist_b_in = jog(wrist_b_ff, axes[jtc_pkg::AXIS_THREE]);
         wrist_a_in = scale_servo(axes[jtc_pkg::AXIS_FIVE]);
         gripper_in = scale_servo(axes[jtc_pkg::AXIS_FOUR]);
      end
   end

   // joint registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff    <= '{deg: 8'd90, frac: 7'd0};
         arm_a_ff   <= '{deg: 8'd40, frac: 7'd0};
         arm_b_ff   <= '{deg: 8'd20, frac: 7'd0};
         wrist_b_ff <= '{deg: 8'd90, frac: 7'd0};
         wrist_a_ff <= 8'd90;
         gripper_ff <= 8'd90;
      end else begin
         root_ff    <= root_in;
         arm_a_ff   <= arm_a_in;
         arm_b_ff   <= arm_b_in;
         wrist_b_ff <= wrist_b_in;
         wrist_a_ff <= wrist_a_in;
         gripper_ff <= gripper_in;
      end
   end

   assign angles.root_deg    = root_ff.deg;
   assign angles.arm_a_deg   = arm_a_ff.deg;
   assign angles.arm_b_deg   = arm_b_ff.deg;
   assign angles.wrist_b_deg = wrist_b_ff.deg;
   assign angles.wrist_a     = wrist_a_ff;
   assign angles.gripper     = gripper_ff;

endmodule

`default_nettype wire

FILE: rtl/core/jtc_track.sv
// one track channel: deadband, linear duty map and direction
`default_nettype none

module jtc_track (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire jtc_pkg::ctrl_type ctrl,
   input  wire jtc_pkg::axis_type axis,
   output jtc_pkg::track_out_type track
);

   logic [7:0]       duty_ff, duty_in;
   jtc_pkg::dir_type dir_ff, dir_in;
   logic [8:0]       delta;
   logic [17:0]      recip;
   logic [26:0]      prod;
   logic             update;

   assign update = ctrl.step && ctrl.fresh && (ctrl.mode == jtc_pkg::MODE_DRIVE);

   // distance from the deadband edge and the matching reciprocal
   always_comb begin
      delta = 9'd0;
      recip = jtc_pkg::DUTY_K_FWD;
      if (axis > jtc_pkg::JOG_HIGH) begin
         delta = 9'(axis - jtc_pkg::JOG_HIGH);
         recip = jtc_pkg::DUTY_K_FWD;
      end else if (axis < jtc_pkg::JOG_LOW) begin
         delta = 9'(jtc_pkg::JOG_LOW - axis);
         recip = jtc_pkg::DUTY_K_REV;
      end
   end

   assign prod = 27'(delta) * 27'(recip);

   // next duty and direction
   always_comb begin
      duty_in = duty_ff;
      dir_in  = dir_ff;
      if (update) begin
         duty_in = prod[jtc_pkg::DUTY_SHIFT +: 8];
         if (axis > jtc_pkg::JOG_HIGH) begin
            dir_in = jtc_pkg::DIR_FWD;
         end else if (axis < jtc_pkg::JOG_LOW) begin
            dir_in = jtc_pkg::DIR_REV;
         end else begin
            dir_in = jtc_pkg::DIR_STOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= 8'd0;
         dir_ff  <= jtc_pkg::DIR_STOP;
      end else begin
         duty_ff <= duty_in;
         dir_ff  <= dir_in;
      end
   end

   assign track.duty = duty_ff;
   assign track.dir  = dir_ff;

endmodule

`default_nettype wire

FILE: rtl/core/jtc_checker.sv
// port-level checks for the joystick teleop controller, bound to the top level
`default_nettype none

module jtc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // pipeline is empty right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // the two arm A servos always mirror each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (8'(rsp_tdata[15:8] + rsp_tdata[23:16]) == 8'd180)
                     && (rsp_tdata[15:8] <= 8'd180))
      else $error("arm A servos not mirrored");

   // a stopped track has no duty, and the direction code is never unused
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[65:64] != 2'd3) && (rsp_tdata[75:74] != 2'd3)
                     && ((rsp_tdata[65:64] != 2'd0) || (rsp_tdata[63:56] == 8'd0))
                     && ((rsp_tdata[75:74] != 2'd0) || (rsp_tdata[73:66] == 8'd0)))
      else $error("track direction or duty out of line");

   // joint servos stay within their travel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] <= 8'd180) && (rsp_tdata[31:24] <= 8'd180)
                     && (rsp_tdata[47:40] <= 8'd180))
      else $error("servo angle beyond travel");

endmodule

bind joystick_teleop_controller jtc_checker u_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the joystick teleop controller: directed and random control passes
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import jtc_pkg::*;

   localparam int unsigned POS_TOP      = 18000;
   localparam int unsigned POS_PER_DEG  = 100;
   localparam int unsigned AXIS_TOP     = 1023;
   localparam int unsigned AXIS_SPAN    = 1024;
   localparam int unsigned DUTY_TOP     = 255;
   localparam int unsigned MAX_WAIT     = 19;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int          RANDOM_PASSES = 1440;
   localparam int          JOG_RUN      = 150;

   // one result transaction, field by field
   typedef struct {
      logic [7:0] root;
      logic [7:0] arm_a_first;
      logic [7:0] arm_a_second;
      logic [7:0] arm_b;
      logic [7:0] wrist_a;
      logic [7:0] wrist_b;
      logic [7:0] gripper;
      logic [7:0] left_duty;
      dir_type    left_dir;
      logic [7:0] right_duty;
      dir_type    right_dir;
   } servo_frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // axis_zero .. axis_five, 10 bits each, zero fill
   logic [1:0]  req_tuser = '0;  // fresh, mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [79:0] rsp_tdata;       // root, arm A first, arm A second, arm B, wrist A, wrist B,
                                 // gripper, left duty, left dir, right duty, right dir

   // behavioral copy of the controller state
   logic          pkt_mode;
   axes_type      pkt_axes;
   int unsigned   root_pos, arm_a_pos, arm_b_pos, wrist_b_pos;
   logic [7:0]    wrist_a_deg, gripper_deg;
   track_out_type left_track, right_track;

   servo_frame_type pending_frames[$];
   int          error_count = 0;
   int          result_count = 0;
   int unsigned cycle_count = 0;
   int unsigned ready_hold = 0;
   bit          no_stall = 1'b0;

   joystick_teleop_controller DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[joystick_teleop_controller] ERROR");
         $finish;
      end
   end

   // one jog step with saturation at both ends
   function automatic int unsigned jog_joint(int unsigned pos, axis_type stick);
      if (stick >= JOG_HIGH) begin
         if (pos < POS_TOP) pos++;
      end else if (stick <= JOG_LOW) begin
         if (pos > 0) pos--;
      end
      return pos;
   endfunction

   function automatic logic [7:0] servo_scale(axis_type stick);
      return 8'((int'(stick) * int'(DEG_MAX)) / AXIS_SPAN);
   endfunction

   // deadband and linear map for one track channel
   function automatic track_out_type stick_to_track(axis_type stick);
      track_out_type t;
      if (stick > JOG_HIGH) begin
         t.duty = 8'(((int'(stick) - int'(JOG_HIGH)) * DUTY_TOP) / (AXIS_TOP - int'(JOG_HIGH)));
         t.dir  = DIR_FWD;
      end else if (stick < JOG_LOW) begin
         t.duty = 8'(((int'(JOG_LOW) - int'(stick)) * DUTY_TOP) / int'(JOG_LOW));
         t.dir  = DIR_REV;
      end else begin
         t.duty = '0;
         t.dir  = DIR_STOP;
      end
      return t;
   endfunction

   function automatic void clear_controller();
      pkt_mode    = MODE_ARM;
      pkt_axes    = '0;
      root_pos    = 9000;
      arm_a_pos   = 4000;
      arm_b_pos   = 2000;
      wrist_b_pos = 9000;
      wrist_a_deg = 8'd90;
      gripper_deg = 8'd90;
      left_track  = '{duty: '0, dir: DIR_STOP};
      right_track = '{duty: '0, dir: DIR_STOP};
   endfunction

   // one control pass: update the held state and form the servo frame
   function automatic servo_frame_type advance_controller(logic fresh, logic mode, axes_type ax);
      servo_frame_type f;
      if (fresh) begin
         pkt_mode = mode;
         pkt_axes = ax;
      end
      if (pkt_mode == MODE_ARM) begin
         root_pos    = jog_joint(root_pos, pkt_axes[AXIS_ONE]);
         arm_a_pos   = jog_joint(arm_a_pos, pkt_axes[AXIS_ZERO]);
         arm_b_pos   = jog_joint(arm_b_pos, pkt_axes[AXIS_TWO]);
         wrist_b_pos = jog_joint(wrist_b_pos, pkt_axes[AXIS_THREE]);
         wrist_a_deg = servo_scale(pkt_axes[AXIS_FIVE]);
         gripper_deg = servo_scale(pkt_axes[AXIS_FOUR]);
      end else if (fresh) begin
         left_track  = stick_to_track(pkt_axes[AXIS_ZERO]);
         right_track = stick_to_track(pkt_axes[AXIS_TWO]);
      end
      f.root         = 8'(root_pos / POS_PER_DEG);
      f.arm_a_first  = 8'(arm_a_pos / POS_PER_DEG);
      f.arm_a_second = 8'(int'(DEG_MAX) - arm_a_pos / POS_PER_DEG);
      f.arm_b        = 8'(int'(DEG_MAX) - arm_b_pos / POS_PER_DEG);
      f.wrist_a      = wrist_a_deg;
      f.wrist_b      = 8'(wrist_b_pos / POS_PER_DEG);
      f.gripper      = gripper_deg;
      f.left_duty    = left_track.duty;
      f.left_dir     = left_track.dir;
      f.right_duty   = right_track.duty;
      f.right_dir    = right_track.dir;
      return f;
   endfunction

   function automatic servo_frame_type unpack_frame(logic [79:0] d);
      servo_frame_type f;
      f.root         = d[7:0];
      f.arm_a_first  = d[15:8];
      f.arm_a_second = d[23:16];
      f.arm_b        = d[31:24];
      f.wrist_a      = d[39:32];
      f.wrist_b      = d[47:40];
      f.gripper      = d[55:48];
      f.left_duty    = d[63:56];
      f.left_dir     = dir_type'(d[65:64]);
      f.right_duty   = d[73:66];
      f.right_dir    = dir_type'(d[75:74]);
      return f;
   endfunction

   function automatic axes_type make_axes(int a0, int a1, int a2, int a3, int a4, int a5);
      axes_type ax;
      ax[AXIS_ZERO]  = axis_type'(a0);
      ax[AXIS_ONE]   = axis_type'(a1);
      ax[AXIS_TWO]   = axis_type'(a2);
      ax[AXIS_THREE] = axis_type'(a3);
      ax[AXIS_FOUR]  = axis_type'(a4);
      ax[AXIS_FIVE]  = axis_type'(a5);
      return ax;
   endfunction

   // stick value weighted toward the extremes and both thresholds
   function automatic axis_type pick_axis();
      case ($urandom_range(0, 7))
         0: begin
            return $urandom_range(0, 1) ? axis_type'(AXIS_TOP) : axis_type'(0);
         end
         1, 2: begin
            return axis_type'(int'(JOG_LOW) - 2 + $urandom_range(0, 4));
         end
         3: begin
            return axis_type'(int'(JOG_HIGH) - 2 + $urandom_range(0, 4));
         end
         default: begin
            return axis_type'($urandom_range(0, AXIS_TOP));
         end
      endcase
   endfunction

   function automatic axes_type random_axes();
      axes_type ax;
      for (int i = 0; i < NUM_AXES; i++) ax[i] = pick_axis();
      return ax;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      $display("result %0d: %s", result_count, msg);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic compare_frames(servo_frame_type got, servo_frame_type want);
      check_field("root_angle", got.root, want.root);
      check_field("arm_a_first_angle", got.arm_a_first, want.arm_a_first);
      check_field("arm_a_second_angle", got.arm_a_second, want.arm_a_second);
      check_field("arm_b_angle", got.arm_b, want.arm_b);
      check_field("wrist_a_angle", got.wrist_a, want.wrist_a);
      check_field("wrist_b_angle", got.wrist_b, want.wrist_b);
      check_field("gripper_angle", got.gripper, want.gripper);
      check_field("left_duty", got.left_duty, want.left_duty);
      check_field("left_dir", got.left_dir, want.left_dir);
      check_field("right_duty", got.right_duty, want.right_duty);
      check_field("right_dir", got.right_dir, want.right_dir);
   endtask

   // result side: check each transaction, then drop rsp_tready for a random stall unless no_stall
   always @(posedge clock) begin : check_results
      servo_frame_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = unpack_frame(rsp_tdata);
         if (pending_frames.size() == 0) report_mismatch("result with no pass waiting");
         else compare_frames(got, pending_frames.pop_front());
         result_count++;
         ready_hold = no_stall ? 0 : $urandom_range(0, MAX_WAIT);
         rsp_tready <= (ready_hold == 0);
      end else if (ready_hold != 0) begin
         ready_hold--;
         if (ready_hold == 0) rsp_tready <= 1'b1;
      end
   end

   // one input transaction, then an optional gap before the next
   task automatic send_pass(input logic fresh, input logic mode, input axes_type ax);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, ax};
      req_tuser  <= {mode, fresh};
      do @(posedge clock); while (!req_tready);
      pending_frames.push_back(advance_controller(fresh, mode, ax));
      gap = no_stall ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // passes before any packet run in arm mode on zero sticks
   task automatic test_startup();
      send_pass(1'b0, MODE_DRIVE, random_axes());
      send_pass(1'b0, MODE_ARM, random_axes());
   endtask

   // arm mode extremes and thresholds, fresh axes used in the same pass
   task automatic test_arm_directed();
      send_pass(1'b1, MODE_ARM, make_axes(AXIS_TOP, AXIS_TOP, AXIS_TOP, AXIS_TOP,
                                          AXIS_TOP, AXIS_TOP));
      send_pass(1'b1, MODE_ARM, make_axes(0, 0, 0, 0, 0, 0));
      send_pass(1'b1, MODE_ARM, make_axes(549, 550, 551, 449, 0, AXIS_TOP));
      send_pass(1'b1, MODE_ARM, make_axes(450, 451, 549, 550, AXIS_TOP, 0));
      send_pass(1'b1, MODE_ARM, make_axes(500, 500, 500, 500, 511, 1));
      send_pass(1'b0, MODE_DRIVE, random_axes());
   endtask

   // drive mode map edges, held values without a fresh packet
   task automatic test_drive_directed();
      send_pass(1'b1, MODE_DRIVE, make_axes(0, 0, AXIS_TOP, 0, 0, 0));
      send_pass(1'b1, MODE_DRIVE, make_axes(449, AXIS_TOP, 551, AXIS_TOP, AXIS_TOP, AXIS_TOP));
      send_pass(1'b1, MODE_DRIVE, make_axes(450, 300, 550, 700, 100, 900));
      send_pass(1'b1, MODE_DRIVE, make_axes(451, 600, 549, 400, 1000, 20));
      send_pass(1'b1, MODE_DRIVE, make_axes(AXIS_TOP, 0, 1, 0, 0, 0));
      send_pass(1'b1, MODE_DRIVE, make_axes(1022, 0, 448, 0, 0, 0));
      send_pass(1'b0, MODE_ARM, random_axes());
      send_pass(1'b0, MODE_DRIVE, random_axes());
      send_pass(1'b1, MODE_ARM, make_axes(500, 500, 500, 500, 700, 300));
   endtask

   // long runs on held sticks, joints cross whole degrees down and up, no idling
   task automatic test_joint_runs();
      no_stall = 1'b1;
      send_pass(1'b1, MODE_ARM, make_axes(0, 0, 0, 0, pick_axis(), pick_axis()));
      repeat (JOG_RUN) send_pass(1'b0, 1'($urandom_range(0, 1)), random_axes());
      send_pass(1'b1, MODE_ARM, make_axes(AXIS_TOP, AXIS_TOP, AXIS_TOP, AXIS_TOP,
                                          pick_axis(), pick_axis()));
      repeat (JOG_RUN) send_pass(1'b0, 1'($urandom_range(0, 1)), random_axes());
      no_stall = 1'b0;
   endtask

   // random mix of fresh packets, single reuse passes and reuse runs
   task automatic test_random_passes();
      int count;
      int run;
      count = 0;
      while (count < RANDOM_PASSES) begin
         if (count % 100 == 0) no_stall = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            6, 7, 8: begin
               send_pass(1'b0, 1'($urandom_range(0, 1)), random_axes());
               count++;
            end
            9: begin
               run = $urandom_range(5, 40);
               repeat (run) send_pass(1'b0, 1'($urandom_range(0, 1)), random_axes());
               count += run;
            end
            default: begin
               send_pass(1'b1, 1'($urandom_range(0, 1)), random_axes());
               count++;
            end
         endcase
      end
      no_stall = 1'b0;
   endtask

   initial begin
      clear_controller();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_startup();
      test_arm_directed();
      test_drive_directed();
      test_joint_runs();
      test_random_passes();

      // drain the remaining results, then allow for the pipeline latency
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("[joystick_teleop_controller] OK");
      end else begin
         $display("[joystick_teleop_controller] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/jtc_pkg.sv
rtl/core/jtc_arm.sv
rtl/core/jtc_track.sv
rtl/core/joystick_teleop_controller.sv
rtl/core/jtc_checker.sv
dv/testbench.sv
